/* src/assert_macros.svh */
// assertion macros used by windowed_rms_overcurrent_detector.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

/* src/wrms_pkg.sv */
`default_nettype none

package wrms_pkg;

   // fixed field widths
   localparam int THR_W       = 15;
   localparam int WLEN_W      = 8;
   localparam int SIW_W       = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int RSP_DATA_W  = 16;

   // parameter defaults
   localparam int MAX_WINDOW_DEF  = 128;
   localparam int SAMPLE_BITS_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_THRESHOLD = 2'd2;

   // register reset values
   localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST     = 8'd100;
   localparam logic [THR_W-1:0]  CURRENT_THRESHOLD_RST = 15'd2020;
   localparam logic [THR_W-1:0]  VOLTAGE_THRESHOLD_RST = 15'd10000;

endpackage

`default_nettype wire

/* src/wrms_mul.sv */
`default_nettype none

module wrms_mul
   import wrms_pkg::*;
#(
   parameter int A_W = 2 * THR_W,
   parameter int B_W = SAMPLE_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [A_W-1:0]     a,
   input  wire logic [B_W-1:0]     b,
   output logic      [A_W+B_W-1:0] p_ff
);

   logic [A_W+B_W-1:0] p_in;

   assign p_in = (A_W+B_W)'(a) * (A_W+B_W)'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

endmodule

`default_nettype wire

/* src/wrms_ring.sv */
`default_nettype none

module wrms_ring
   import wrms_pkg::*;
#(
   parameter int DEPTH  = MAX_WINDOW_DEF,
   parameter int DATA_W = 2 * SAMPLE_BITS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] ring_mem [DEPTH];

   // read-first: a read of the entry being overwritten returns the old word
   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff        <= ring_mem[rd_addr];
         ring_mem[wr_addr] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* src/windowed_rms_overcurrent_detector.sv */
// channel | dir | ports                        | payload
// req     | in  | req_tvalid/tready/tdata      | current_sample, voltage_sample
// rsp     | out | rsp_tvalid/tready/tdata      | overcurrent, breaker_closed,
//         |     |                              | samples_in_window
// csr     | in  | csr_valid/ready/index/data   | register index, write data
//
// the result is registered in the last step; a new pair is taken only once the sequencer is idle again
// the single shared multiplier forms eight products per pair, one per cycle
// req_tready is high only while the sequencer is idle and no csr write is offered;
// a result waiting on rsp_tready holds the sequencer in its last step
// reset is synchronous; it clears the window and the sums and loads the registers with their reset values
// the sample ring is not cleared; only entries written since restart are used
`default_nettype none
`include "assert_macros.svh"

module windowed_rms_overcurrent_detector
   import wrms_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int REQ_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [SAMPLE_BITS-1:0] current_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] voltage_sample
   input  wire logic [REQ_W-1:0]      req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] overcurrent, [1] breaker_closed, [9:2] samples_in_window
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int LEN_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
   localparam int SB    = SAMPLE_BITS;
   localparam int SUM_W = 2 * SB - 1 + $clog2(MAX_WINDOW);
   localparam int MA_W  = (2 * THR_W > SB) ? 2 * THR_W : SB;
   localparam int MB_T  = (THR_W > SB) ? THR_W : SB;
   localparam int MB_W  = (MB_T > CNT_W) ? MB_T : CNT_W;
   localparam int P_W   = MA_W + MB_W;
   localparam int CMP_W = (SUM_W > P_W) ? SUM_W : P_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQOC,
      S_SQOV,
      S_SQNC,
      S_SQNV,
      S_THC,
      S_THCN,
      S_THV,
      S_THVN,
      S_CMP
   } state_type;

   state_type          state_ff, state_in;
   logic [WLEN_W-1:0]  wlen_ff, wlen_in;
   logic [THR_W-1:0]   cthr_ff, cthr_in;
   logic [THR_W-1:0]   vthr_ff, vthr_in;
   logic [IDX_W-1:0]   wp_ff, wp_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [SUM_W-1:0]   csum_ff, csum_in;
   logic [SUM_W-1:0]   vsum_ff, vsum_in;
   logic               evict_ff, evict_in;
   logic               cover_ff, cover_in;
   logic [SB-1:0]      cs_ff, cs_in;
   logic [SB-1:0]      vs_ff, vs_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ovc_ff, rsp_ovc_in;
   logic [SIW_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic [LEN_W-1:0]   len_wide;
   logic [CNT_W-1:0]   len;
   logic [CNT_W:0]     old_sum;
   logic [IDX_W-1:0]   old_addr;
   logic               req_acc;
   logic               csr_acc;
   logic [2*SB-1:0]    rd_data;
   logic [SB-1:0]      old_c, old_v;
   logic [SB-1:0]      mag_in;
   logic               mul_en;
   logic [MA_W-1:0]    mul_a;
   logic [MB_W-1:0]    mul_b;
   logic [P_W-1:0]     prod;
   logic [SUM_W-1:0]   prod_sum;
   logic [CMP_W-1:0]   prod_cmp;

   // a register write offered in the same cycle goes first
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SIW_W - 2){1'b0}}, rsp_cnt_ff, !rsp_ovc_ff, rsp_ovc_ff};

   // effective window: zero acts as one, clipped to the ring depth
   always_comb begin
      len_wide = LEN_W'(wlen_ff);
      if (wlen_ff == '0) begin
         len_wide = LEN_W'(1);
      end else if (len_wide > LEN_W'(MAX_WINDOW)) begin
         len_wide = LEN_W'(MAX_WINDOW);
      end
   end
   assign len = CNT_W'(len_wide);

   // oldest entry of the window, modulo the ring depth
   always_comb begin
      old_sum = (CNT_W+1)'(wp_ff) + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(len);
      if (old_sum >= (CNT_W+1)'(MAX_WINDOW)) begin
         old_sum = old_sum - (CNT_W+1)'(MAX_WINDOW);
      end
   end
   assign old_addr = IDX_W'(old_sum);

   wrms_ring #(
      .DEPTH  (MAX_WINDOW),
      .DATA_W (2 * SB),
      .ADDR_W (IDX_W)
   ) u_ring (
      .clock      (clock),
      .en         (req_acc),
      .wr_addr    (wp_ff),
      .wr_data    (req_tdata[2*SB-1:0]),
      .rd_addr    (old_addr),
      .rd_data_ff (rd_data)
   );

   assign old_c = rd_data[SB-1:0];
   assign old_v = rd_data[2*SB-1:SB];

   // operand select for the shared multiplier
   always_comb begin
      mag_in = cs_ff;
      mul_en = 1'b1;
      case (state_ff)
         S_SQOC:  mag_in = old_c;
         S_SQOV:  mag_in = old_v;
         S_SQNC:  mag_in = cs_ff;
         S_SQNV:  mag_in = vs_ff;
         default: mul_en = (state_ff != S_IDLE) && (state_ff != S_CMP);
      endcase
      if (mag_in[SB-1]) begin
         mag_in = ~mag_in + SB'(1);
      end
      case (state_ff)
         S_THC: begin
            mul_a = MA_W'(cthr_ff);
            mul_b = MB_W'(cthr_ff);
         end
         S_THV: begin
            mul_a = MA_W'(vthr_ff);
            mul_b = MB_W'(vthr_ff);
         end
         S_THCN, S_THVN: begin
            mul_a = MA_W'(prod[2*THR_W-1:0]);
            mul_b = MB_W'(fill_ff);
         end
         default: begin
            mul_a = MA_W'(mag_in);
            mul_b = MB_W'(mag_in);
         end
      endcase
   end

   wrms_mul #(
      .A_W (MA_W),
      .B_W (MB_W)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p_ff  (prod)
   );

   assign prod_sum = SUM_W'(prod);
   assign prod_cmp = CMP_W'(prod);

   always_comb begin
      state_in     = state_ff;
      wlen_in      = wlen_ff;
      cthr_in      = cthr_ff;
      vthr_in      = vthr_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      csum_in      = csum_ff;
      vsum_in      = vsum_ff;
      evict_in     = evict_ff;
      cover_in     = cover_ff;
      cs_in        = cs_ff;
      vs_in        = vs_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ovc_in   = rsp_ovc_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_acc) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               wlen_in = csr_data[WLEN_W-1:0];
               wp_in   = '0;
               fill_in = '0;
               csum_in = '0;
               vsum_in = '0;
            end
            CSR_CURRENT_THRESHOLD: cthr_in = csr_data[THR_W-1:0];
            CSR_VOLTAGE_THRESHOLD: vthr_in = csr_data[THR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               cs_in    = req_tdata[SB-1:0];
               vs_in    = req_tdata[2*SB-1:SB];
               evict_in = (fill_ff >= len);
               fill_in  = (fill_ff >= len) ? len : fill_ff + CNT_W'(1);
               wp_in    = (wp_ff == IDX_W'(MAX_WINDOW - 1)) ? '0 : wp_ff + IDX_W'(1);
               state_in = S_SQOC;
            end
         end
         S_SQOC: state_in = S_SQOV;
         S_SQOV: begin
            if (evict_ff) begin
               csum_in = csum_ff - prod_sum;
            end
            state_in = S_SQNC;
         end
         S_SQNC: begin
            if (evict_ff) begin
               vsum_in = vsum_ff - prod_sum;
            end
            state_in = S_SQNV;
         end
         S_SQNV: begin
            csum_in  = csum_ff + prod_sum;
            state_in = S_THC;
         end
         S_THC: begin
            vsum_in  = vsum_ff + prod_sum;
            state_in = S_THCN;
         end
         S_THCN: state_in = S_THV;
         S_THV: begin
            cover_in = CMP_W'(csum_ff) > prod_cmp;
            state_in = S_THVN;
         end
         S_THVN: state_in = S_CMP;
         S_CMP: begin
            // hold here while the previous word is still waiting
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ovc_in   = cover_ff && (CMP_W'(vsum_ff) > prod_cmp);
               rsp_cnt_in   = SIW_W'(fill_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wlen_ff      <= WINDOW_LENGTH_RST;
         cthr_ff      <= CURRENT_THRESHOLD_RST;
         vthr_ff      <= VOLTAGE_THRESHOLD_RST;
         wp_ff        <= '0;
         fill_ff      <= '0;
         csum_ff      <= '0;
         vsum_ff      <= '0;
         evict_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         cthr_ff      <= cthr_in;
         vthr_ff      <= vthr_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         csum_ff      <= csum_in;
         vsum_ff      <= vsum_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cover_ff   <= cover_in;
      cs_ff      <= cs_in;
      vs_ff      <= vs_in;
      rsp_ovc_ff <= rsp_ovc_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   `ASSERT_NEVER(a_fill_within_len, clock, reset, fill_ff > len, "fill count above window")
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_acc |=> (state_ff != S_IDLE), "idle after accept")
   `ASSERT_CLK(a_fill_after_accept, clock, reset, req_acc |=> (fill_ff != '0), "empty window after accept")
   `ASSERT_CLK(a_result_ends_item, clock, reset, ($rose(rsp_valid_ff) |-> (state_ff == S_IDLE)), "result without finished item")

endmodule

`default_nettype wire
